@@ hw/rtl/cmep_pkg.sv @@
// ----------------------------------------------------------------------------
// cmep_pkg: shared types and constants of the current mean/EMA/peak monitor
// Field widths, accumulation limits, register indexes and divider request types.
// ----------------------------------------------------------------------------
package cmep_pkg;

	localparam int CHANNELS = 2;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int SAMPLE_W = 20;   // current sample / mean width
	localparam int SUM_W    = 48;   // accumulator width
	localparam int CNT_W    = 30;   // sample counter width
	localparam int FRAC_W   = 16;   // EMA fraction bits
	localparam int EMA_W    = SAMPLE_W + FRAC_W;
	localparam int DIFF_W   = EMA_W + 1;
	localparam int CFG_W    = 16;
	localparam int PROD_W   = DIFF_W + CFG_W + 1;
	localparam int TIME_W   = 32;

	localparam logic [CNT_W-1:0]        COUNT_LIMIT    = CNT_W'(1000000000);
	localparam logic signed [SUM_W-1:0] SUM_LIMIT      = SUM_W'(64'sd100000000000000);
	localparam logic signed [SUM_W-1:0] SUM_LIMIT_NEG  = -SUM_LIMIT;

	// Config register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_ALPHA  = REG_IDX_W'(1);

	localparam logic [CFG_W-1:0] PERIOD_RESET = CFG_W'(100);
	localparam logic [CFG_W-1:0] ALPHA_RESET  = CFG_W'(218);

	// Divider: a mean always fits SAMPLE_W bits, so only that many steps run
	localparam int DIV_STEPS = SAMPLE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [CNT_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                       done;
		logic signed [SAMPLE_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ hw/rtl/current_mean_ema_peak_monitor.sv @@
// ----------------------------------------------------------------------------
// current_mean_ema_peak_monitor: per-channel current statistics
// Window mean, exponential average, lifetime mean and peak for two channels.
// ----------------------------------------------------------------------------
// One request carries a channel, a signed 20-bit current sample (0.01 mA) and
// a millisecond timestamp; it produces exactly one result with that channel's
// window mean, EMA integer part, lifetime mean, peak and a refreshed flag.
// The block takes one request at a time: sample_ready is high only while the
// sequencer is idle. A plain sample adds to the window sum, checks its limits,
// adds to the lifetime sum and peak, checks those limits, tests the refresh
// period and then loads the result. Each fold of a sum into its mean (count
// or sum limit reached) runs one division, and a refresh runs a window mean,
// an EMA update and a lifetime mean for each channel (no window mean for an
// empty window, no EMA update or lifetime mean for a channel with no samples
// yet). Every mean comes from the single shared 20-step divider. A finished
// result waits in the output register, so the next request is accepted while
// it is still pending. Config writes are taken at any time; they should only
// be issued while the block is idle.
// ----------------------------------------------------------------------------
module current_mean_ema_peak_monitor (
	input  logic                                clk,
	input  logic                                arst_n,
	// config
	input  logic                                cfg_we,
	input  logic [cmep_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [cmep_pkg::CFG_W-1:0]          cfg_data,
	// sample requests
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic                                channel,
	input  logic signed [cmep_pkg::SAMPLE_W-1:0] current_sample,
	input  logic [cmep_pkg::TIME_W-1:0]         time_ms,
	// results
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                out_channel,
	output logic signed [cmep_pkg::SAMPLE_W-1:0] window_mean,
	output logic signed [cmep_pkg::SAMPLE_W-1:0] smoothed_mean,
	output logic signed [cmep_pkg::SAMPLE_W-1:0] lifetime_mean,
	output logic signed [cmep_pkg::SAMPLE_W-1:0] peak_current,
	output logic                                refreshed
);

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ACC      = 4'd1;   // add sample to window or lifetime
	localparam logic [3:0] S_FOLD_CHK = 4'd2;   // limit check on the new sum/count
	localparam logic [3:0] S_FOLD_DIV = 4'd3;   // wait for fold mean
	localparam logic [3:0] S_TIME     = 4'd4;   // refresh period check
	localparam logic [3:0] S_R_WIN    = 4'd5;   // refresh: start window mean
	localparam logic [3:0] S_R_WDIV   = 4'd6;
	localparam logic [3:0] S_R_DIFF   = 4'd7;   // EMA: target minus current
	localparam logic [3:0] S_R_MUL    = 4'd8;   // EMA: times alpha
	localparam logic [3:0] S_R_EMA    = 4'd9;   // EMA update, start lifetime mean
	localparam logic [3:0] S_R_LDIV   = 4'd10;
	localparam logic [3:0] S_OUT      = 4'd11;

	localparam int SW = cmep_pkg::SAMPLE_W;
	localparam int CH = cmep_pkg::CHANNELS;

	logic [3:0] state_q;

	// config registers
	logic [cmep_pkg::CFG_W-1:0] period_q;
	logic [cmep_pkg::CFG_W-1:0] alpha_q;

	// per-channel statistics
	logic signed [cmep_pkg::SUM_W-1:0]  wsum_q [CH];
	logic [cmep_pkg::CNT_W-1:0]         wcnt_q [CH];
	logic signed [cmep_pkg::SUM_W-1:0]  lsum_q [CH];
	logic [cmep_pkg::CNT_W-1:0]         lcnt_q [CH];
	logic signed [SW-1:0]               wavg_q [CH];
	logic signed [SW-1:0]               lavg_q [CH];
	logic signed [cmep_pkg::EMA_W-1:0]  ema_q  [CH];
	logic signed [SW-1:0]               peak_q [CH];
	logic signed [SW-1:0]               last_q [CH];
	logic [cmep_pkg::TIME_W-1:0]        refresh_time_q;

	// request being worked on
	logic                               ch_q;
	logic signed [SW-1:0]               x_q;
	logic [cmep_pkg::TIME_W-1:0]        now_q;
	logic [cmep_pkg::CH_W-1:0]          p_q;     // channel pointer
	logic                               life_q;  // 1: lifetime accumulator
	logic                               refresh_q;
	logic signed [cmep_pkg::DIFF_W-1:0] diff_q;
	logic signed [cmep_pkg::PROD_W-1:0] prod_q;

	// datapath
	logic signed [cmep_pkg::SUM_W-1:0]  sel_sum;
	logic [cmep_pkg::CNT_W-1:0]         sel_cnt;
	logic signed [cmep_pkg::SUM_W-1:0]  x_ext;
	logic                               fold;
	logic [cmep_pkg::TIME_W-1:0]        elapsed;
	logic signed [cmep_pkg::SUM_W-1:0]  q_ext;
	logic signed [cmep_pkg::PROD_W-1:0] mult;
	logic                               div_life;
	logic                               out_load;
	logic                               last_ch;

	cmep_pkg::div_req_t div_req;
	cmep_pkg::div_rsp_t div_rsp;

	assign sel_sum = life_q ? lsum_q[p_q] : wsum_q[p_q];
	assign sel_cnt = life_q ? lcnt_q[p_q] : wcnt_q[p_q];
	assign x_ext   = {{(cmep_pkg::SUM_W - SW){x_q[SW-1]}}, x_q};
	assign q_ext   = {{(cmep_pkg::SUM_W - SW){div_rsp.quotient[SW-1]}}, div_rsp.quotient};

	// fold on count limit or on sum magnitude limit, either sign
	assign fold = (sel_cnt >= cmep_pkg::COUNT_LIMIT) || (sel_sum >= cmep_pkg::SUM_LIMIT)
	           || (sel_sum <= cmep_pkg::SUM_LIMIT_NEG);

	assign elapsed = now_q - refresh_time_q;
	assign mult    = $signed({1'b0, alpha_q}) * diff_q;
	assign last_ch = (p_q == cmep_pkg::CH_W'(CH - 1));

	// lifetime operands for a fold on the lifetime sum and for the refresh mean
	assign div_life = (state_q == S_R_EMA) || ((state_q == S_FOLD_CHK) && life_q);

	assign div_req.start = ((state_q == S_FOLD_CHK) && fold)
	                    || ((state_q == S_R_WIN) && (wcnt_q[p_q] != '0))
	                    || ((state_q == S_R_EMA));
	assign div_req.dividend = div_life ? lsum_q[p_q] : wsum_q[p_q];
	assign div_req.divisor  = div_life ? lcnt_q[p_q] : wcnt_q[p_q];

	cmep_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign sample_ready = (state_q == S_IDLE);
	assign out_load     = (state_q == S_OUT) && (!result_valid || result_ready);

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= cmep_pkg::PERIOD_RESET;
			alpha_q  <= cmep_pkg::ALPHA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cmep_pkg::REG_PERIOD: period_q <= cfg_data;
				cmep_pkg::REG_ALPHA:  alpha_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			p_q            <= '0;
			life_q         <= 1'b0;
			refresh_q      <= 1'b0;
			refresh_time_q <= '0;
			for (int i = 0; i < CH; i++) begin
				wsum_q[i] <= '0;
				wcnt_q[i] <= '0;
				lsum_q[i] <= '0;
				lcnt_q[i] <= '0;
				wavg_q[i] <= '0;
				lavg_q[i] <= '0;
				ema_q[i]  <= '0;
				peak_q[i] <= '0;
				last_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						p_q     <= cmep_pkg::CH_W'(channel);
						life_q  <= 1'b0;
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (life_q) begin
						lsum_q[p_q] <= sel_sum + x_ext;
						lcnt_q[p_q] <= sel_cnt + 1'b1;
						last_q[p_q] <= x_q;
						if (x_q > peak_q[p_q]) begin
							peak_q[p_q] <= x_q;
						end
					end else begin
						wsum_q[p_q] <= sel_sum + x_ext;
						wcnt_q[p_q] <= sel_cnt + 1'b1;
					end
					state_q <= S_FOLD_CHK;
				end
				S_FOLD_CHK: begin
					if (fold) begin
						state_q <= S_FOLD_DIV;
					end else if (life_q) begin
						state_q <= S_TIME;
					end else begin
						life_q  <= 1'b1;
						state_q <= S_ACC;
					end
				end
				S_FOLD_DIV: begin
					if (div_rsp.done) begin
						if (life_q) begin
							lavg_q[p_q] <= div_rsp.quotient;
							lsum_q[p_q] <= q_ext;
							lcnt_q[p_q] <= cmep_pkg::CNT_W'(1);
							state_q     <= S_TIME;
						end else begin
							wavg_q[p_q] <= div_rsp.quotient;
							wsum_q[p_q] <= q_ext;
							wcnt_q[p_q] <= cmep_pkg::CNT_W'(1);
							life_q      <= 1'b1;
							state_q     <= S_ACC;
						end
					end
				end
				S_TIME: begin
					// unsigned wrap-around elapsed time
					if (elapsed >= cmep_pkg::TIME_W'(period_q)) begin
						refresh_q      <= 1'b1;
						refresh_time_q <= now_q;
						p_q            <= '0;
						state_q        <= S_R_WIN;
					end else begin
						refresh_q <= 1'b0;
						state_q   <= S_OUT;
					end
				end
				S_R_WIN: begin
					if (wcnt_q[p_q] != '0) begin
						state_q <= S_R_WDIV;
					end else begin
						state_q <= S_R_DIFF;
					end
				end
				S_R_WDIV: begin
					if (div_rsp.done) begin
						wavg_q[p_q] <= div_rsp.quotient;
						wsum_q[p_q] <= '0;
						wcnt_q[p_q] <= '0;
						state_q     <= S_R_DIFF;
					end
				end
				S_R_DIFF: begin
					if (lcnt_q[p_q] != '0) begin
						diff_q  <= {last_q[p_q][SW-1], last_q[p_q], {cmep_pkg::FRAC_W{1'b0}}}
						         - {ema_q[p_q][cmep_pkg::EMA_W-1], ema_q[p_q]};
						state_q <= S_R_MUL;
					end else if (last_ch) begin
						state_q <= S_OUT;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= S_R_WIN;
					end
				end
				S_R_MUL: begin
					prod_q  <= mult;
					state_q <= S_R_EMA;
				end
				S_R_EMA: begin
					// arithmetic shift of the product is the floor of /65536
					ema_q[p_q] <= ema_q[p_q] + prod_q[cmep_pkg::FRAC_W +: cmep_pkg::EMA_W];
					state_q    <= S_R_LDIV;
				end
				S_R_LDIV: begin
					if (div_rsp.done) begin
						lavg_q[p_q] <= div_rsp.quotient;
						if (last_ch) begin
							state_q <= S_OUT;
						end else begin
							p_q     <= p_q + 1'b1;
							state_q <= S_R_WIN;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			ch_q  <= channel;
			x_q   <= current_sample;
			now_q <= time_ms;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_load) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_channel   <= ch_q;
			window_mean   <= wavg_q[ch_q];
			smoothed_mean <= ema_q[ch_q][cmep_pkg::FRAC_W +: SW];
			lifetime_mean <= lavg_q[ch_q];
			peak_current  <= peak_q[ch_q];
			refreshed     <= refresh_q;
		end
	end

endmodule

@@ hw/rtl/cmep_div.sv @@
// ----------------------------------------------------------------------------
// cmep_div: iterative signed-by-unsigned mean divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module cmep_div (
	input  logic               clk,
	input  logic               arst_n,
	input  cmep_pkg::div_req_t req,
	output cmep_pkg::div_rsp_t rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [cmep_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic                                neg_q;
	logic [cmep_pkg::CNT_W-1:0]          rem_q;
	logic [cmep_pkg::SAMPLE_W-1:0]       lo_q;
	logic [cmep_pkg::CNT_W-1:0]          divisor_q;
	logic signed [cmep_pkg::SAMPLE_W-1:0] quot_q;

	logic [cmep_pkg::SUM_W-1:0]          mag;
	logic [cmep_pkg::CNT_W:0]            shifted;
	logic [cmep_pkg::CNT_W:0]            trial;
	logic                                ge;
	logic [cmep_pkg::CNT_W-1:0]          rem_nx;
	logic [cmep_pkg::SAMPLE_W-1:0]       lo_nx;

	assign mag = req.dividend[cmep_pkg::SUM_W-1] ? -req.dividend : req.dividend;

	assign shifted = {rem_q, lo_q[cmep_pkg::SAMPLE_W-1]};
	assign trial   = shifted - {1'b0, divisor_q};
	assign ge      = ~trial[cmep_pkg::CNT_W];
	assign rem_nx  = ge ? trial[cmep_pkg::CNT_W-1:0] : shifted[cmep_pkg::CNT_W-1:0];
	assign lo_nx   = {lo_q[cmep_pkg::SAMPLE_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmep_pkg::DIV_CNT_W'(cmep_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// high part of |dividend| is always below the divisor (mean fits SAMPLE_W)
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q     <= req.dividend[cmep_pkg::SUM_W-1];
			rem_q     <= cmep_pkg::CNT_W'(mag[cmep_pkg::SUM_W-1:cmep_pkg::SAMPLE_W]);
			lo_q      <= mag[cmep_pkg::SAMPLE_W-1:0];
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			lo_q  <= lo_nx;
			if (cnt_q == '0) begin
				quot_q <= neg_q ? -lo_nx : lo_nx;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

@@ hw/rtl/cmep_chk.sv @@
// ----------------------------------------------------------------------------
// cmep_chk: port-level checks for the current mean/EMA/peak monitor
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module cmep_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                sample_valid,
	input logic                                sample_ready,
	input logic                                result_valid,
	input logic                                result_ready,
	input logic signed [cmep_pkg::SAMPLE_W-1:0] window_mean,
	input logic signed [cmep_pkg::SAMPLE_W-1:0] peak_current
);

	// one request at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> !sample_ready)
		else $error("sample_ready high right after an accepted request");

	// a new result appears exactly when the sequencer returns to idle
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> sample_ready)
		else $error("result issued while sequencer not idle");

	// peak starts at zero and only grows
	a_peak_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !peak_current[cmep_pkg::SAMPLE_W-1])
		else $error("negative peak reported");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(window_mean)
			&& $stable(peak_current)))
		else $error("stalled result dropped or changed");

endmodule

bind current_mean_ema_peak_monitor cmep_chk u_cmep_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.window_mean  (window_mean),
	.peak_current (peak_current)
);
